// ===== src/ssme_pkg.sv =====
package ssme_pkg;

  // Word width of values and results
  localparam int DATA_W = 32;

  // Default store depth
  localparam int DEPTH_DEF = 16;

  // Control from the sequencer to the value store
  typedef struct packed {
    logic wr_en;    // write one word and mark it live
    logic clr_one;  // clear the live bit of the extracted entry
    logic clr_all;  // clear every live bit at the end of a set
  } ssme_st_ctrl_t;

endpackage

// ===== src/ssme_if.sv =====
// Input channel: one value word per handshake
interface ssme_in_if import ssme_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] value;
  logic                     last_item;

  modport source (output valid, output value, output last_item, input ready);
  modport sink (input valid, input value, input last_item, output ready);
endinterface

// Result channel: one sorted word per handshake
interface ssme_out_if import ssme_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] sorted_value;
  logic                     last_result;
  logic                     overflow;

  modport source (output valid, output sorted_value, output last_result,
                  output overflow, input ready);
  modport sink (input valid, input sorted_value, input last_result,
                input overflow, output ready);
endinterface

// ===== src/ssme_store.sv =====
module ssme_store import ssme_pkg::*; #(
  parameter int DEPTH  = DEPTH_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ssme_st_ctrl_t            ctrl,
  input  logic [ADDR_W-1:0]        wr_addr,
  input  logic signed [DATA_W-1:0] wr_data,
  input  logic [ADDR_W-1:0]        rd_addr,
  input  logic [ADDR_W-1:0]        clr_addr,
  output logic signed [DATA_W-1:0] rd_data,
  output logic                     rd_live
);

  logic signed [DATA_W-1:0] mem_r [DEPTH];
  logic [DEPTH-1:0]         live_r;
  logic signed [DATA_W-1:0] rd_data_r;
  logic                     rd_live_r;

  // Value memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  // Live bits, one per entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r    <= '0;
      rd_live_r <= 1'b0;
    end else begin
      rd_live_r <= live_r[rd_addr];
      if (ctrl.clr_all) begin
        live_r <= '0;
      end else begin
        if (ctrl.wr_en) begin
          live_r[wr_addr] <= 1'b1;
        end
        if (ctrl.clr_one) begin
          live_r[clr_addr] <= 1'b0;
        end
      end
    end
  end

  assign rd_data = rd_data_r;
  assign rd_live = rd_live_r;

endmodule

// ===== src/ssme_seq.sv =====
module ssme_seq import ssme_pkg::*; #(
  parameter int DEPTH  = DEPTH_DEF,
  parameter int ADDR_W = $clog2(DEPTH),
  parameter int CNT_W  = $clog2(DEPTH + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // input side
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic                     in_last,
  // result side
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_value,
  output logic                     out_last,
  output logic                     out_ovf,
  // store side
  output ssme_st_ctrl_t            st_ctrl,
  output logic [ADDR_W-1:0]        wr_addr,
  output logic signed [DATA_W-1:0] wr_data,
  output logic [ADDR_W-1:0]        rd_addr,
  output logic [ADDR_W-1:0]        clr_addr,
  input  logic signed [DATA_W-1:0] rd_data,
  input  logic                     rd_live
);

  localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

  typedef enum logic [1:0] {S_COLLECT, S_SCAN, S_EMIT} state_t;

  state_t                   state_r, state_nxt;
  logic [CNT_W-1:0]         fill_r, fill_nxt;
  logic                     dropped_r, dropped_nxt;
  logic [CNT_W-1:0]         remain_r, remain_nxt;
  logic [CNT_W-1:0]         rd_cnt_r, rd_cnt_nxt;
  logic                     pend_r, pend_nxt;
  logic [ADDR_W-1:0]        pend_addr_r, pend_addr_nxt;
  logic                     have_best_r, have_best_nxt;
  logic signed [DATA_W-1:0] best_val_r, best_val_nxt;
  logic [ADDR_W-1:0]        best_idx_r, best_idx_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] out_value_r, out_value_nxt;
  logic                     out_last_r, out_last_nxt;
  logic                     out_ovf_r, out_ovf_nxt;

  logic accept, rd_issue, take, scan_done, out_take;

  // Handshake and scan status
  assign in_ready  = (state_r == S_COLLECT);
  assign accept    = in_valid & in_ready;
  assign rd_issue  = (state_r == S_SCAN) && (rd_cnt_r < fill_r);
  // shared comparator: strict less keeps the earliest entry on ties
  assign take      = pend_r && rd_live && (!have_best_r || (rd_data < best_val_r));
  assign scan_done = (state_r == S_SCAN) && (rd_cnt_r == fill_r) && !pend_r;
  assign out_take  = out_valid_r & out_ready;

  // Store access
  assign wr_addr          = fill_r[ADDR_W-1:0];
  assign wr_data          = in_value;
  assign rd_addr          = rd_cnt_r[ADDR_W-1:0];
  assign clr_addr         = best_idx_r;
  assign st_ctrl.wr_en    = accept && (fill_r < FULL);
  assign st_ctrl.clr_one  = scan_done;
  assign st_ctrl.clr_all  = (state_r == S_EMIT) && out_take && (remain_r == CNT_W'(1));

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    dropped_nxt   = dropped_r;
    remain_nxt    = remain_r;
    rd_cnt_nxt    = rd_cnt_r;
    pend_nxt      = 1'b0;
    pend_addr_nxt = rd_cnt_r[ADDR_W-1:0];
    have_best_nxt = have_best_r;
    best_val_nxt  = best_val_r;
    best_idx_nxt  = best_idx_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;

    case (state_r)
      S_COLLECT: begin
        if (accept) begin
          if (fill_r < FULL) begin
            fill_nxt = fill_r + CNT_W'(1);
          end else begin
            dropped_nxt = 1'b1;
          end
          if (in_last) begin
            remain_nxt    = (fill_r < FULL) ? fill_r + CNT_W'(1) : fill_r;
            rd_cnt_nxt    = '0;
            have_best_nxt = 1'b0;
            state_nxt     = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (rd_issue) begin
          rd_cnt_nxt = rd_cnt_r + CNT_W'(1);
          pend_nxt   = 1'b1;
        end
        if (take) begin
          have_best_nxt = 1'b1;
          best_val_nxt  = rd_data;
          best_idx_nxt  = pend_addr_r;
        end
        if (scan_done) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = best_val_r;
          out_last_nxt  = (remain_r == CNT_W'(1));
          out_ovf_nxt   = dropped_r;
          state_nxt     = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_take) begin
          out_valid_nxt = 1'b0;
          if (remain_r == CNT_W'(1)) begin
            fill_nxt    = '0;
            dropped_nxt = 1'b0;
            state_nxt   = S_COLLECT;
          end else begin
            rd_cnt_nxt    = '0;
            have_best_nxt = 1'b0;
            state_nxt     = S_SCAN;
          end
          remain_nxt = remain_r - CNT_W'(1);
        end
      end
      default: begin
        state_nxt = S_COLLECT;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_COLLECT;
      fill_r      <= '0;
      dropped_r   <= 1'b0;
      remain_r    <= '0;
      rd_cnt_r    <= '0;
      pend_r      <= 1'b0;
      have_best_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      dropped_r   <= dropped_nxt;
      remain_r    <= remain_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      pend_r      <= pend_nxt;
      have_best_r <= have_best_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pend_addr_r <= pend_addr_nxt;
    best_val_r  <= best_val_nxt;
    best_idx_r  <= best_idx_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;
  assign out_ovf   = out_ovf_r;

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FULL)
    else $error("fill count beyond store depth");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid_r))
    else $error("input taken while a result is pending");

  a_remain_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (remain_r != '0) && (fill_r != '0))
    else $error("scan with nothing left to extract");

  a_set_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_take && out_last_r) |=> (fill_r == '0) && !dropped_r && in_ready)
    else $error("store not emptied after the final result");

endmodule

// ===== src/selection_sort_min_extract_top.sv =====
// Values are taken one word per cycle while the store collects a set.
// After the last value of a set with N stored words, each result takes
// a scan of one comparator over the store memory plus its output handshake.
// No input is taken from the last value until the final result is taken.
// Synchronous active-low reset empties the store and clears the result side.
module selection_sort_min_extract_top import ssme_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input logic          clk,
  input logic          rst_n,
  ssme_in_if.sink      in_ch,
  ssme_out_if.source   out_ch
);

  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  ssme_st_ctrl_t            st_ctrl;
  logic [ADDR_W-1:0]        wr_addr;
  logic signed [DATA_W-1:0] wr_data;
  logic [ADDR_W-1:0]        rd_addr;
  logic [ADDR_W-1:0]        clr_addr;
  logic signed [DATA_W-1:0] rd_data;
  logic                     rd_live;

  // Sequencer with the shared comparator
  ssme_seq #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W),
    .CNT_W  (CNT_W)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_value  (in_ch.value),
    .in_last   (in_ch.last_item),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_value (out_ch.sorted_value),
    .out_last  (out_ch.last_result),
    .out_ovf   (out_ch.overflow),
    .st_ctrl   (st_ctrl),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr),
    .clr_addr  (clr_addr),
    .rd_data   (rd_data),
    .rd_live   (rd_live)
  );

  // Value store with live bits
  ssme_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (st_ctrl),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_addr  (rd_addr),
    .clr_addr (clr_addr),
    .rd_data  (rd_data),
    .rd_live  (rd_live)
  );

endmodule
